// ----- rtl/mntt_pkg.sv -----
`timescale 1ns / 1ps

package mntt_pkg;

    localparam int DivW   = 32;
    localparam int LenW   = 19;
    localparam int OnW    = 29;
    localparam int OffW   = 26;
    localparam int TempoW = 10;

    localparam logic [TempoW-1:0] TempoReset = 10'd120;
    localparam logic [DivW-1:0]   WholeNum   = 32'd240000;
    localparam logic [DivW-1:0]   CountNum   = 32'd2000000000;
    localparam logic [DivW-1:0]   DivSpan    = 32'd60000;
    localparam logic [15:0]       DivMin     = 16'd16;
    localparam logic [OnW-1:0]    OnScale    = 29'd900;
    localparam logic [OffW-1:0]   OffScale   = 26'd100;

    localparam logic OpPlay    = 1'b0;
    localparam logic OpRestart = 1'b1;

    typedef struct packed {
        logic              op;
        logic [15:0]       note_frequency;
        logic signed [7:0] note_length;
    } in_beat_t;

    typedef struct packed {
        logic            tone_on;
        logic [15:0]     clock_divider;
        logic [15:0]     wrap_top;
        logic [6:0]      compare_level;
        logic [OnW-1:0]  on_time_us;
        logic [OffW-1:0] off_time_us;
        logic            melody_end;
    } out_beat_t;

    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DivW-1:0] divisor;
    } div_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WHOLE,
        S_LEN,
        S_COUNT,
        S_DIVV,
        S_TOP,
        S_MUL,
        S_DONE
    } state_t;

endpackage

// ----- rtl/mntt_div.sv -----
`timescale 1ns / 1ps

module mntt_div
    import mntt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  div_req_t        req,
    output logic            done,
    output logic [DivW-1:0] quotient
);

    localparam int CntW = $clog2(DivW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [DivW-1:0] rem_reg, rem_next;
    logic [DivW-1:0] quo_reg, quo_next;
    logic [DivW-1:0] dsr_reg, dsr_next;
    logic [DivW:0]   rem_sh;
    logic [DivW:0]   diff;
    logic            ge;

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    assign rem_sh = {rem_reg, quo_reg[DivW-1]};
    assign diff   = rem_sh - {1'b0, dsr_reg};
    assign ge     = !diff[DivW];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(DivW - 1);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DivW-1:0] : rem_sh[DivW-1:0];
            quo_next = {quo_reg[DivW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/mntt_mul.sv -----
`timescale 1ns / 1ps

module mntt_mul
    import mntt_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [LenW-1:0] len,
    output logic            done,
    output logic [OnW-1:0]  on_time,
    output logic [OffW-1:0] off_time
);

    localparam int CntW = $clog2(LenW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [LenW-1:0] len_reg, len_next;
    logic [OnW-1:0]  on_add_reg, on_add_next;
    logic [OffW-1:0] off_add_reg, off_add_next;
    logic [OnW-1:0]  on_acc_reg, on_acc_next;
    logic [OffW-1:0] off_acc_reg, off_acc_next;

    // shift-add, one bit of the length per cycle, lsb first
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        on_add_next  = on_add_reg;
        off_add_next = off_add_reg;
        on_acc_next  = on_acc_reg;
        off_acc_next = off_acc_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CntW'(LenW - 1);
            len_next     = len;
            on_add_next  = OnScale;
            off_add_next = OffScale;
            on_acc_next  = '0;
            off_acc_next = '0;
        end
        else if (busy_reg)
        begin
            if (len_reg[0])
            begin
                on_acc_next  = on_acc_reg + on_add_reg;
                off_acc_next = off_acc_reg + off_add_reg;
            end
            len_next     = {1'b0, len_reg[LenW-1:1]};
            on_add_next  = {on_add_reg[OnW-2:0], 1'b0};
            off_add_next = {off_add_reg[OffW-2:0], 1'b0};
            cnt_next     = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        on_add_reg  <= on_add_next;
        off_add_reg <= off_add_next;
        on_acc_reg  <= on_acc_next;
        off_acc_reg <= off_acc_next;
    end

    assign done     = done_reg;
    assign on_time  = on_acc_reg;
    assign off_time = off_acc_reg;

endmodule

// ----- rtl/melody_note_tone_timing.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// in        input      in_valid / in_ready     in_data  (in_beat_t)
// out       output     out_valid / out_ready   out_data (out_beat_t)
// cfg       input      cfg_we                  cfg_data (tempo_bpm)
//
// one note at a time through a shared restoring divider and a shift-add
// multiplier: a tone note uses five divides and the multiply, a rest two
// divides and the multiply, a zero computed length two divides, and restart,
// a zero code or tempo and notes after the end neither.
// reset clears the end flag, sets tempo to 120 and empties the output.
// a finished beat waits in the output register; the next note is taken
// while it waits and stalls only at its own hand-off.

module melody_note_tone_timing
    import mntt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [TempoW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_beat_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_beat_t         out_data
);

    state_t            state_reg, state_next;
    logic [TempoW-1:0] tempo_reg;
    logic              fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_data_reg, out_data_next;
    in_beat_t          beat_reg, beat_next;
    out_beat_t         res_reg, res_next;
    logic [DivW-1:0]   count_reg, count_next;
    logic [15:0]       div_reg, div_next;
    logic [LenW-1:0]   len_reg, len_next;

    div_req_t          div_req;
    logic              div_done;
    logic [DivW-1:0]   div_q;
    logic              mul_start;
    logic              mul_done;
    logic [OnW-1:0]    mul_on;
    logic [OffW-1:0]   mul_off;

    logic [7:0]        code;
    logic [7:0]        mag;
    logic              dotted;
    logic [DivW-1:0]   whole3;
    logic [LenW-1:0]   len_q;

    mntt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // length is taken as it is being stored, so a rest can start right away
    mntt_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .len      (len_next),
        .done     (mul_done),
        .on_time  (mul_on),
        .off_time (mul_off)
    );

    assign code   = beat_reg.note_length;
    assign dotted = code[7];
    assign mag    = 8'(8'd0 - code);
    assign whole3 = div_q + {div_q[DivW-2:0], 1'b0};
    // dotted length is halved after the divide
    assign len_q  = dotted ? div_q[LenW:1] : div_q[LenW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        beat_next      = beat_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        div_next       = div_reg;
        len_next       = len_reg;
        div_req        = '0;
        mul_start      = 1'b0;
        in_ready       = (state_reg == S_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    beat_next  = in_data;
                    res_next   = '0;
                    state_next = S_DONE;
                    if (in_data.op == OpRestart)
                    begin
                        fin_next = 1'b0;
                    end
                    else if (fin_reg)
                    begin
                        res_next.melody_end = 1'b1;
                    end
                    else if (tempo_reg == '0 || in_data.note_length == 8'sd0)
                    begin
                        fin_next            = 1'b1;
                        res_next.melody_end = 1'b1;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = WholeNum;
                        div_req.divisor  = DivW'(tempo_reg);
                        state_next       = S_WHOLE;
                    end
                end
            end
            S_WHOLE:
            begin
                if (div_done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = dotted ? whole3 : div_q;
                    div_req.divisor  = dotted ? DivW'(mag) : DivW'(code);
                    state_next       = S_LEN;
                end
            end
            S_LEN:
            begin
                if (div_done)
                begin
                    len_next = len_q;
                    if (len_q == '0)
                    begin
                        fin_next            = 1'b1;
                        res_next.melody_end = 1'b1;
                        state_next          = S_DONE;
                    end
                    else if (beat_reg.note_frequency != '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = CountNum;
                        div_req.divisor  = DivW'(beat_reg.note_frequency);
                        state_next       = S_COUNT;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_COUNT:
            begin
                if (div_done)
                begin
                    count_next       = div_q;
                    div_req.start    = 1'b1;
                    div_req.dividend = div_q;
                    div_req.divisor  = DivSpan;
                    state_next       = S_DIVV;
                end
            end
            S_DIVV:
            begin
                if (div_done)
                begin
                    div_next         = (div_q < DivW'(DivMin)) ? DivMin : div_q[15:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = count_reg;
                    div_req.divisor  = (div_q < DivW'(DivMin)) ? DivW'(DivMin) : div_q;
                    state_next       = S_TOP;
                end
            end
            S_TOP:
            begin
                if (div_done)
                begin
                    res_next.tone_on       = 1'b1;
                    res_next.clock_divider = div_reg;
                    res_next.wrap_top      = div_q[15:0];
                    res_next.compare_level = div_q[15:9];
                    mul_start              = 1'b1;
                    state_next             = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    res_next.on_time_us  = mul_on;
                    res_next.off_time_us = mul_off;
                    state_next           = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            tempo_reg     <= TempoReset;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tempo_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        beat_reg     <= beat_next;
        res_reg      <= res_next;
        count_reg    <= count_next;
        div_reg      <= div_next;
        len_reg      <= len_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- sim/melody_note_tone_timing_tb.sv -----
`timescale 1ns / 1ps

module melody_note_tone_timing_tb
    import mntt_pkg::*;
();

    localparam int unsigned NoteWholeNum = 240000;
    localparam int unsigned PwmCount     = 2000000000;
    localparam int unsigned DivRange     = 60000;
    localparam int unsigned DivFloor     = 16;
    localparam int unsigned LevelDiv     = 512;
    localparam int unsigned OnMul        = 900;
    localparam int unsigned OffMul       = 100;
    localparam int          HoldCycles   = 800;
    localparam int          WatchdogMax  = 4000;
    localparam int          DrainCycles  = 300;
    localparam int          RandomTarget = 640;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [TempoW-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_beat_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_beat_t         out_data;

    // model of the block
    logic [TempoW-1:0] tempo_model = TempoReset;
    logic              melody_done = 1'b0;
    out_beat_t         pending_tones[$];

    // traffic shaping
    logic send_gaps   = 1'b1;
    logic recv_stalls = 1'b1;
    logic hold_req    = 1'b0;
    int   hold_left   = 0;
    int   stall_left  = 0;
    int   quiet_cycles = 0;

    // bookkeeping
    int notes_sent   = 0;
    int beats_seen   = 0;
    int mismatches   = 0;
    int n_tones      = 0;
    int n_rests      = 0;
    int n_ends       = 0;
    int n_after_end  = 0;
    int n_restarts   = 0;
    int n_tempos     = 0;

    melody_note_tone_timing uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic in_beat_t mk_note(logic op, logic [15:0] freq, logic signed [7:0] code);
        in_beat_t b;
        b.op             = op;
        b.note_frequency = freq;
        b.note_length    = code;
        return b;
    endfunction

    // works out the tone settings and timing of one note, updates the end flag
    function automatic out_beat_t predict_tone(in_beat_t b);
        out_beat_t   r;
        logic [31:0] whole;
        logic [31:0] len;
        logic [31:0] mag;
        logic [31:0] count;
        logic [31:0] div;
        logic [31:0] top;
        logic [63:0] on_full;
        logic [63:0] off_full;
        r = '0;
        if (b.op == OpRestart)
        begin
            melody_done = 1'b0;
            n_restarts++;
            return r;
        end
        if (melody_done)
        begin
            r.melody_end = 1'b1;
            n_after_end++;
            return r;
        end
        whole = (tempo_model == '0) ? 32'd0 : NoteWholeNum / {22'd0, tempo_model};
        if (b.note_length == 8'sd0)
            len = 32'd0;
        else if (!b.note_length[7])
            len = whole / {24'd0, b.note_length};
        else
        begin
            // dotted: magnitude of the code runs 1..128
            mag = 32'd256 - {24'd0, b.note_length};
            len = ((32'd3 * whole) / mag) / 32'd2;
        end
        if (len == 32'd0)
        begin
            melody_done  = 1'b1;
            r.melody_end = 1'b1;
            n_ends++;
            return r;
        end
        if (b.note_frequency != 16'd0)
        begin
            count = PwmCount / {16'd0, b.note_frequency};
            div   = count / DivRange;
            if (div < DivFloor)
                div = DivFloor;
            top             = count / div;
            r.tone_on       = 1'b1;
            r.clock_divider = div[15:0];
            r.wrap_top      = top[15:0];
            r.compare_level = 7'(top / LevelDiv);
            n_tones++;
        end
        else
            n_rests++;
        on_full       = {32'd0, len} * OnMul;
        off_full      = {32'd0, len} * OffMul;
        r.on_time_us  = on_full[OnW-1:0];
        r.off_time_us = off_full[OffW-1:0];
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s on result %0d: expected %0d, got %0d",
                         name, beats_seen, want, got);
        end
    endtask

    task automatic check_beat(out_beat_t got);
        out_beat_t want;
        if (pending_tones.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with nothing pending: %p", got);
            return;
        end
        want = pending_tones.pop_front();
        compare_field("tone_on",       32'(want.tone_on),       32'(got.tone_on));
        compare_field("clock_divider", 32'(want.clock_divider), 32'(got.clock_divider));
        compare_field("wrap_top",      32'(want.wrap_top),      32'(got.wrap_top));
        compare_field("compare_level", 32'(want.compare_level), 32'(got.compare_level));
        compare_field("on_time_us",    32'(want.on_time_us),    32'(got.on_time_us));
        compare_field("off_time_us",   32'(want.off_time_us),   32'(got.off_time_us));
        compare_field("melody_end",    32'(want.melody_end),    32'(got.melody_end));
        beats_seen++;
    endtask

    // output side: checks each beat and decides ready for the next edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                check_beat(out_data);
            if (hold_req)
            begin
                hold_left = HoldCycles;
                hold_req <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (recv_stalls && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WatchdogMax)
            begin
                $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge where the beat was taken
    task automatic send_note(in_beat_t b);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_tones.push_back(predict_tone(b));
        notes_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tones.size() != 0);
    endtask

    task automatic write_tempo(logic [TempoW-1:0] bpm);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= bpm;
        @(posedge clk);
        cfg_we      <= 1'b0;
        tempo_model = bpm;
        n_tempos++;
    endtask

    function automatic logic [15:0] rand_freq();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 2100));
            2: return 16'($urandom_range(60000, 65535));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [7:0] rand_code();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [TempoW-1:0] rand_tempo();
        case ($urandom_range(0, 9))
            0: return 10'd1;
            1: return 10'd1023;
            2: return 10'd0;
            3: return 10'($urandom_range(1, 30));
            default: return 10'($urandom_range(1, 1023));
        endcase
    endfunction

    task automatic test_directed_notes();
        send_note(mk_note(OpPlay, 16'd440, 8'sd4));
        send_note(mk_note(OpPlay, 16'd0, 8'sd4));        // rest
        send_note(mk_note(OpPlay, 16'd1, 8'sd1));        // largest divider
        send_note(mk_note(OpPlay, 16'd65535, 8'sd127));
        send_note(mk_note(OpPlay, 16'd2083, -8'sd1));    // longest dotted
        send_note(mk_note(OpPlay, 16'd2084, -8'sd128));  // divider at its floor
        send_note(mk_note(OpPlay, 16'd1000, 8'sd8));
        send_note(mk_note(OpPlay, 16'd65535, -8'sd2));
        send_note(mk_note(OpRestart, 16'd0, 8'sd0));     // restart while still playing
        send_note(mk_note(OpPlay, 16'd262, 8'sd0));      // end of melody
        send_note(mk_note(OpPlay, 16'd523, 8'sd4));      // ignored after the end
        send_note(mk_note(OpPlay, 16'd0, -8'sd4));
        send_note(mk_note(OpRestart, 16'hFFFF, -8'sd1));
        send_note(mk_note(OpPlay, 16'd880, 8'sd2));
    endtask

    task automatic test_tempo_extremes();
        logic [TempoW-1:0] bpms[5];
        bpms = '{10'd1, 10'd1023, 10'd0, 10'd60, TempoReset};
        foreach (bpms[i])
        begin
            write_tempo(bpms[i]);
            send_note(mk_note(OpRestart, 16'd0, 8'sd0));
            send_note(mk_note(OpPlay, 16'd440, 8'sd1));
            send_note(mk_note(OpPlay, 16'd0, -8'sd1));
            send_note(mk_note(OpPlay, 16'd65535, 8'sd127));
            send_note(mk_note(OpPlay, 16'd1, -8'sd128));
            send_note(mk_note(OpPlay, 16'd880, 8'sd4));
        end
    endtask

    // output stalls for a long stretch while notes keep coming
    task automatic test_output_backpressure();
        send_note(mk_note(OpRestart, 16'd0, 8'sd0));
        send_gaps = 1'b0;
        hold_req <= 1'b1;
        repeat (24)
            send_note(mk_note(OpPlay, rand_freq(), rand_code()));
        send_gaps = 1'b1;
    endtask

    task automatic test_input_pause();
        repeat (2)
        begin
            repeat (8)
                send_note(mk_note(OpPlay, rand_freq(), rand_code()));
            wait_drained();
        end
    endtask

    task automatic play_phrase(int notes);
        if (melody_done || $urandom_range(0, 7) == 0)
            send_note(mk_note(OpRestart, rand_freq(), 8'($urandom_range(0, 255))));
        repeat (notes)
        begin
            // some noise among the notes: anything the fields allow
            if ($urandom_range(0, 9) == 0)
                send_note(mk_note(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                                  8'($urandom_range(0, 255))));
            else
                send_note(mk_note(OpPlay, rand_freq(), rand_code()));
        end
        if ($urandom_range(0, 4) != 0)
        begin
            send_note(mk_note(OpPlay, rand_freq(), 8'sd0));
            if ($urandom_range(0, 2) == 0)
                send_note(mk_note(OpPlay, rand_freq(), rand_code()));
        end
    endtask

    task automatic test_random_melodies();
        while (notes_sent < RandomTarget)
        begin
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                write_tempo(rand_tempo());
            play_phrase($urandom_range(2, 20));
        end
    endtask

    task automatic test_full_rate();
        write_tempo(10'($urandom_range(60, 240)));
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        send_note(mk_note(OpRestart, 16'd0, 8'sd0));
        repeat (60)
            send_note(mk_note(OpPlay, rand_freq(), rand_code()));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_notes();
        test_tempo_extremes();
        test_output_backpressure();
        test_input_pause();
        test_random_melodies();
        test_full_rate();

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        mismatches += pending_tones.size();

        $display("%0d notes sent, %0d results checked over %0d tempo writes",
                 notes_sent, beats_seen, n_tempos);
        $display("%0d tones, %0d rests, %0d melody ends, %0d notes after end, %0d restarts",
                 n_tones, n_rests, n_ends, n_after_end, n_restarts);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mntt_pkg.sv
rtl/mntt_div.sv
rtl/mntt_mul.sv
rtl/melody_note_tone_timing.sv
sim/melody_note_tone_timing_tb.sv
